@@ src/friction_field_sampler_assert.svh @@
// Assertion macros shared by the sampler top level.
`ifndef FRICTION_FIELD_SAMPLER_ASSERT_SVH
`define FRICTION_FIELD_SAMPLER_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define FFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffs: next-cycle check failed");

// Consequent checked in the same cycle as the antecedent.
`define FFS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffs: same-cycle check failed");

`endif

@@ src/ffs_pkg.sv @@
package ffs_pkg;

	localparam int MAX_GRID_WIDTH  = 256;
	localparam int MAX_GRID_HEIGHT = 256;
	localparam int MAX_SPILLS      = 16;
	localparam int GRID_DEPTH      = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
	localparam int GRID_AW         = $clog2(GRID_DEPTH);
	localparam int SP_IW           = (MAX_SPILLS > 1) ? $clog2(MAX_SPILLS) : 1;
	localparam int CFG_IW          = 3;
	localparam int CFG_DW          = 32;

	localparam logic [16:0] ONE_Q14  = 17'd16384;
	localparam logic [4:0]  SQRT_LAST = 5'd31;
	localparam logic [4:0]  DIV_LAST  = 5'd15;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_ADD,
		CMD_REMOVE,
		CMD_SAMPLE
	} cmd_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_GRID_WIDTH,
		REG_GRID_HEIGHT,
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_CELLS_PER_UNIT,
		REG_MIN_FACTOR,
		REG_FIELD_ENABLED
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_GRID_WR,
		OP_SPILL_ADD,
		OP_SPILL_DEL,
		OP_SETUP,
		OP_RX_MUL,
		OP_RX_CHK,
		OP_RY_MUL,
		OP_RY_CHK,
		OP_CELL_SEL,
		OP_WT_MUL,
		OP_CELL_MUL,
		OP_ACC,
		OP_RASTER,
		OP_SP_DIFF,
		OP_SP_MX,
		OP_SP_MY,
		OP_SP_MR,
		OP_SP_CORE,
		OP_SQRT_INIT,
		OP_SQRT,
		OP_NUM,
		OP_DIV,
		OP_MIX_MUL,
		OP_MIX,
		OP_SP_NEXT,
		OP_FINAL
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RX_MUL,
		ST_RX_CHK,
		ST_RY_MUL,
		ST_RY_CHK,
		ST_CELL_SEL,
		ST_WT_MUL,
		ST_CELL_MUL,
		ST_ACC,
		ST_RASTER,
		ST_SP_DIFF,
		ST_SP_CHK,
		ST_SP_MY,
		ST_SP_MR,
		ST_SP_CMP,
		ST_SQRT,
		ST_NUM,
		ST_DIV,
		ST_MIX_MUL,
		ST_MIX,
		ST_SP_NEXT,
		ST_FINAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic raster_skip;
		logic cell_last;
		logic sp_skip;
		logic sp_far;
		logic sp_core;
		logic sp_last;
		logic sqrt_last;
		logic div_last;
	} dp_stat_t;

endpackage

@@ src/ffs_ram.sv @@
module ffs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/ffs_ctrl.sv @@
module ffs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ffs_pkg::dp_stat_t  stat,
	output ffs_pkg::dp_cmd_t   cmd,
	output logic               busy,
	output logic               done
);
	import ffs_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.cmd)
					CMD_LOAD: begin
						cmd.op  = OP_GRID_WR;
						state_d = ST_DONE;
					end
					CMD_ADD: begin
						cmd.op  = OP_SPILL_ADD;
						state_d = ST_DONE;
					end
					CMD_REMOVE: begin
						cmd.op  = OP_SPILL_DEL;
						state_d = ST_DONE;
					end
					default: begin
						cmd.op  = OP_SETUP;
						state_d = ST_RX_MUL;
					end
				endcase
			end
			ST_RX_MUL: begin
				cmd.op  = OP_RX_MUL;
				state_d = ST_RX_CHK;
			end
			ST_RX_CHK: begin
				cmd.op  = OP_RX_CHK;
				state_d = ST_RY_MUL;
			end
			ST_RY_MUL: begin
				cmd.op  = OP_RY_MUL;
				state_d = ST_RY_CHK;
			end
			ST_RY_CHK: begin
				cmd.op  = OP_RY_CHK;
				state_d = ST_CELL_SEL;
			end
			ST_CELL_SEL: begin
				cmd.op  = OP_CELL_SEL;
				state_d = stat.raster_skip ? ST_SP_DIFF : ST_WT_MUL;
			end
			ST_WT_MUL: begin
				cmd.op  = OP_WT_MUL;
				state_d = ST_CELL_MUL;
			end
			ST_CELL_MUL: begin
				cmd.op  = OP_CELL_MUL;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = stat.cell_last ? ST_RASTER : ST_WT_MUL;
			end
			ST_RASTER: begin
				cmd.op  = OP_RASTER;
				state_d = ST_SP_DIFF;
			end
			ST_SP_DIFF: begin
				cmd.op  = OP_SP_DIFF;
				state_d = ST_SP_CHK;
			end
			ST_SP_CHK: begin
				if (stat.sp_skip) begin
					state_d = ST_SP_NEXT;
				end else begin
					cmd.op  = OP_SP_MX;
					state_d = ST_SP_MY;
				end
			end
			ST_SP_MY: begin
				cmd.op  = OP_SP_MY;
				state_d = ST_SP_MR;
			end
			ST_SP_MR: begin
				cmd.op  = OP_SP_MR;
				state_d = ST_SP_CMP;
			end
			ST_SP_CMP: begin
				if (stat.sp_far) begin
					state_d = ST_SP_NEXT;
				end else if (stat.sp_core) begin
					cmd.op  = OP_SP_CORE;
					state_d = ST_SP_NEXT;
				end else begin
					cmd.op  = OP_SQRT_INIT;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.op  = OP_SQRT;
				state_d = stat.sqrt_last ? ST_NUM : ST_SQRT;
			end
			ST_NUM: begin
				cmd.op  = OP_NUM;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op  = OP_DIV;
				state_d = stat.div_last ? ST_MIX_MUL : ST_DIV;
			end
			ST_MIX_MUL: begin
				cmd.op  = OP_MIX_MUL;
				state_d = ST_MIX;
			end
			ST_MIX: begin
				cmd.op  = OP_MIX;
				state_d = ST_SP_NEXT;
			end
			ST_SP_NEXT: begin
				cmd.op  = OP_SP_NEXT;
				state_d = stat.sp_last ? ST_FINAL : ST_SP_DIFF;
			end
			ST_FINAL: begin
				cmd.op  = OP_FINAL;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/ffs_dp.sv @@
module ffs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    command,
	input  logic signed [31:0]            point_x,
	input  logic signed [31:0]            point_y,
	input  logic [15:0]                   cell_index,
	input  logic [15:0]                   factor_value,
	input  logic [7:0]                    spill_tag,
	input  logic [30:0]                   spill_radius,
	input  logic                          cfg_we,
	input  logic [ffs_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [ffs_pkg::CFG_DW-1:0]    cfg_data,
	input  ffs_pkg::dp_cmd_t              cmd,
	output ffs_pkg::dp_stat_t             stat,
	output logic [15:0]                   friction_factor,
	output logic                          status
);
	import ffs_pkg::*;

	// configuration
	logic [8:0]  grid_width_q, grid_height_q;
	logic [31:0] origin_x_q, origin_y_q, cpu_q;
	logic [15:0] min_factor_q;
	logic        field_en_q;

	// captured transaction
	cmd_t        cmd_q;
	logic [31:0] px_q, py_q;
	logic [15:0] cidx_q, fv_q;
	logic [7:0]  tag_q;
	logic [30:0] rad_q;

	// spill table
	logic        sp_valid_q [MAX_SPILLS];
	logic [7:0]  sp_id_q    [MAX_SPILLS];
	logic [31:0] sp_cx_q    [MAX_SPILLS];
	logic [31:0] sp_cy_q    [MAX_SPILLS];
	logic [30:0] sp_size_q  [MAX_SPILLS];
	logic [15:0] sp_core_q  [MAX_SPILLS];

	// working registers
	logic [32:0] dx_q, dy_q;
	logic        skip_q;
	logic [25:0] ux_q, vy_q;
	logic [8:0]  col0_q, col1_q, row0_q, row1_q;
	logic [15:0] fx_q, fy_q;
	logic [63:0] prod_q;
	logic [48:0] acc_q;
	logic [16:0] raster_q, best_q;
	logic [1:0]  k_q;
	logic [SP_IW-1:0] idx_q;
	logic [32:0] adx_q, ady_q;
	logic [63:0] d2_q, n_q, root_q, bit_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [15:0] q_q;
	logic [15:0] res_factor_q;
	logic        res_status_q;

	// combinational
	logic [8:0]  weff, heff;
	logic [32:0] dx_w, dy_w;
	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_p;
	logic        hit, free;
	logic [SP_IW-1:0] hit_idx, free_idx, slot;
	logic [26:0] tx, ty;
	logic [10:0] cx, ry, wm1, hm1;
	logic [16:0] wx, wy;
	logic [8:0]  row_sel, col_sel;
	logic [17:0] lin_addr;
	logic        grid_we;
	logic [GRID_AW-1:0] grid_addr;
	logic [15:0] grid_rdata;
	logic [30:0] r_cur;
	logic [15:0] mu;
	logic [32:0] ddx, ddy;
	logic [63:0] rb;
	logic [32:0] num_w, rem2;
	logic [15:0] mix_mag;
	logic [33:0] mix_base, mix_w;
	logic [16:0] region;
	logic [16:0] fin;
	logic        any_valid;

	always_comb begin
		if (grid_width_q == 9'd0) begin
			weff = 9'd1;
		end else if (32'(grid_width_q) > MAX_GRID_WIDTH) begin
			weff = 9'(MAX_GRID_WIDTH);
		end else begin
			weff = grid_width_q;
		end
		if (grid_height_q == 9'd0) begin
			heff = 9'd1;
		end else if (32'(grid_height_q) > MAX_GRID_HEIGHT) begin
			heff = 9'(MAX_GRID_HEIGHT);
		end else begin
			heff = grid_height_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 9'd1;
			grid_height_q <= 9'd1;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			cpu_q         <= 32'd65536;
			min_factor_q  <= '0;
			field_en_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_WIDTH:     grid_width_q  <= cfg_data[8:0];
				REG_GRID_HEIGHT:    grid_height_q <= cfg_data[8:0];
				REG_ORIGIN_X:       origin_x_q    <= cfg_data;
				REG_ORIGIN_Y:       origin_y_q    <= cfg_data;
				REG_CELLS_PER_UNIT: cpu_q         <= cfg_data;
				REG_MIN_FACTOR:     min_factor_q  <= cfg_data[15:0];
				REG_FIELD_ENABLED:  field_en_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// lowest matching tag wins, else lowest free slot
	always_comb begin
		hit      = 1'b0;
		free     = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = MAX_SPILLS - 1; i >= 0; i--) begin
			if (sp_valid_q[i] && sp_id_q[i] == tag_q) begin
				hit     = 1'b1;
				hit_idx = SP_IW'(i);
			end
			if (!sp_valid_q[i]) begin
				free     = 1'b1;
				free_idx = SP_IW'(i);
			end
		end
		slot = hit ? hit_idx : free_idx;
		any_valid = 1'b0;
		for (int i = 0; i < MAX_SPILLS; i++) begin
			any_valid = any_valid | sp_valid_q[i];
		end
	end

	assign dx_w = {px_q[31], px_q} - {origin_x_q[31], origin_x_q};
	assign dy_w = {py_q[31], py_q} - {origin_y_q[31], origin_y_q};

	// cell-centre coordinates shifted by one cell so they stay non-negative
	assign tx  = 27'(ux_q) + 27'(32768);
	assign ty  = 27'({heff, 16'd0}) + 27'(32768) - 27'(vy_q);
	assign cx  = tx[26:16];
	assign ry  = ty[26:16];
	assign wm1 = 11'(weff) - 11'd1;
	assign hm1 = 11'(heff) - 11'd1;

	assign wx = k_q[0] ? {1'b0, fx_q} : 17'd65536 - {1'b0, fx_q};
	assign wy = k_q[1] ? {1'b0, fy_q} : 17'd65536 - {1'b0, fy_q};
	assign col_sel = k_q[0] ? col1_q : col0_q;
	assign row_sel = k_q[1] ? row1_q : row0_q;
	assign lin_addr = 18'(row_sel) * 18'(weff) + 18'(col_sel);

	assign grid_we   = (cmd.op == OP_GRID_WR) && (32'(cidx_q) < GRID_DEPTH);
	assign grid_addr = (cmd.op == OP_GRID_WR) ? GRID_AW'(cidx_q) : GRID_AW'(lin_addr);

	ffs_ram #(
		.WIDTH(16),
		.DEPTH(GRID_DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (grid_we),
		.addr  (grid_addr),
		.wdata (fv_q),
		.rdata (grid_rdata)
	);

	assign r_cur = sp_size_q[idx_q];
	assign mu    = sp_core_q[idx_q];
	assign ddx   = {px_q[31], px_q} - {sp_cx_q[idx_q][31], sp_cx_q[idx_q]};
	assign ddy   = {py_q[31], py_q} - {sp_cy_q[idx_q][31], sp_cy_q[idx_q]};
	assign rb    = root_q + bit_q;
	assign num_w = {root_q[31:0], 1'b0} - {2'b00, r_cur};
	assign rem2  = {rem_q, 1'b0};

	assign mix_mag  = (mu <= ONE_Q14[15:0]) ? ONE_Q14[15:0] - mu : mu - ONE_Q14[15:0];
	assign mix_base = 34'({mu, 16'd0}) + 34'(32768);
	assign mix_w    = (mu <= ONE_Q14[15:0]) ? mix_base + prod_q[33:0] : mix_base - prod_q[33:0];
	assign region   = mix_w[32:16];

	always_comb begin
		fin = raster_q;
		if (any_valid && best_q < fin) begin
			fin = best_q;
		end
		if (fin < {1'b0, min_factor_q}) begin
			fin = {1'b0, min_factor_q};
		end
	end

	// shared multiplier
	always_comb begin
		case (cmd.op)
			OP_RX_MUL: begin
				mul_a = 33'(dx_q[31:0]);
				mul_b = 33'(cpu_q);
			end
			OP_RY_MUL: begin
				mul_a = 33'(dy_q[31:0]);
				mul_b = 33'(cpu_q);
			end
			OP_WT_MUL: begin
				mul_a = 33'(wx);
				mul_b = 33'(wy);
			end
			OP_CELL_MUL: begin
				mul_a = 33'(grid_rdata);
				mul_b = prod_q[32:0];
			end
			OP_SP_MX: begin
				mul_a = adx_q;
				mul_b = adx_q;
			end
			OP_SP_MY: begin
				mul_a = ady_q;
				mul_b = ady_q;
			end
			OP_SP_MR: begin
				mul_a = 33'(r_cur);
				mul_b = 33'(r_cur);
			end
			OP_MIX_MUL: begin
				mul_a = 33'(q_q);
				mul_b = 33'(mix_mag);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 66'(mul_a) * 66'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SPILLS; i++) begin
				sp_valid_q[i] <= 1'b0;
			end
			k_q          <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			res_status_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CAPTURE: begin
					res_status_q <= 1'b0;
				end
				OP_SPILL_ADD: begin
					if (!(hit || free)) begin
						res_status_q <= 1'b1;
					end else begin
						sp_valid_q[slot] <= 1'b1;
					end
				end
				OP_SPILL_DEL: begin
					for (int i = 0; i < MAX_SPILLS; i++) begin
						if (sp_valid_q[i] && sp_id_q[i] == tag_q) begin
							sp_valid_q[i] <= 1'b0;
						end
					end
				end
				OP_CELL_SEL: begin
					k_q   <= '0;
					idx_q <= '0;
				end
				OP_ACC:       k_q   <= k_q + 2'd1;
				OP_SP_NEXT:   idx_q <= idx_q + SP_IW'(1);
				OP_SQRT_INIT: cnt_q <= '0;
				OP_NUM:       cnt_q <= '0;
				OP_SQRT:      cnt_q <= cnt_q + 5'd1;
				OP_DIV:       cnt_q <= cnt_q + 5'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				cmd_q        <= cmd_t'(command);
				px_q         <= point_x;
				py_q         <= point_y;
				cidx_q       <= cell_index;
				fv_q         <= factor_value;
				tag_q        <= spill_tag;
				rad_q        <= spill_radius;
				res_factor_q <= '0;
			end
			OP_SPILL_ADD: begin
				if (hit || free) begin
					sp_id_q[slot]   <= tag_q;
					sp_cx_q[slot]   <= px_q;
					sp_cy_q[slot]   <= py_q;
					sp_size_q[slot] <= rad_q;
					sp_core_q[slot] <= (fv_q > min_factor_q) ? fv_q : min_factor_q;
				end
			end
			OP_SETUP: begin
				dx_q   <= dx_w;
				dy_q   <= dy_w;
				skip_q <= !field_en_q || cpu_q == '0 || dx_w[32] || dy_w[32];
			end
			OP_RX_CHK: begin
				if (prod_q > {23'd0, weff, 32'd0}) begin
					skip_q <= 1'b1;
				end
				ux_q <= prod_q[41:16];
			end
			OP_RY_CHK: begin
				if (prod_q > {23'd0, heff, 32'd0}) begin
					skip_q <= 1'b1;
				end
				vy_q <= prod_q[41:16];
			end
			OP_CELL_SEL: begin
				col0_q   <= (cx == '0) ? 9'd0 : ((cx - 11'd1 > wm1) ? 9'(wm1) : 9'(cx - 11'd1));
				col1_q   <= (cx > wm1) ? 9'(wm1) : 9'(cx);
				row0_q   <= (ry == '0) ? 9'd0 : ((ry - 11'd1 > hm1) ? 9'(hm1) : 9'(ry - 11'd1));
				row1_q   <= (ry > hm1) ? 9'(hm1) : 9'(ry);
				fx_q     <= tx[15:0];
				fy_q     <= ty[15:0];
				raster_q <= ONE_Q14;
				best_q   <= ONE_Q14;
				acc_q    <= '0;
			end
			OP_ACC:    acc_q    <= acc_q + prod_q[48:0];
			OP_RASTER: raster_q <= 17'((50'(acc_q) + 50'(64'h8000_0000)) >> 32);
			OP_SP_DIFF: begin
				adx_q <= ddx[32] ? 33'(0) - ddx : ddx;
				ady_q <= ddy[32] ? 33'(0) - ddy : ddy;
			end
			OP_SP_MY: d2_q <= prod_q;
			OP_SP_MR: d2_q <= d2_q + prod_q;
			OP_SP_CORE: begin
				if ({1'b0, mu} < best_q) begin
					best_q <= {1'b0, mu};
				end
			end
			OP_SQRT_INIT: begin
				n_q    <= d2_q;
				root_q <= '0;
				bit_q  <= 64'd1 << 62;
			end
			OP_SQRT: begin
				if (n_q >= rb) begin
					n_q    <= n_q - rb;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_NUM: begin
				rem_q <= num_w[32] ? 32'd0 : num_w[31:0];
				q_q   <= '0;
			end
			OP_DIV: begin
				if (rem2 >= {2'b00, r_cur}) begin
					rem_q <= 32'(rem2 - {2'b00, r_cur});
					q_q   <= {q_q[14:0], 1'b1};
				end else begin
					rem_q <= rem2[31:0];
					q_q   <= {q_q[14:0], 1'b0};
				end
			end
			OP_MIX: begin
				if (region < best_q) begin
					best_q <= region;
				end
			end
			OP_FINAL: res_factor_q <= fin[15:0];
			default: ;
		endcase
		case (cmd.op)
			OP_RX_MUL, OP_RY_MUL, OP_WT_MUL, OP_CELL_MUL,
			OP_SP_MX, OP_SP_MY, OP_SP_MR, OP_MIX_MUL: prod_q <= mul_p[63:0];
			default: ;
		endcase
	end

	always_comb begin
		stat.cmd         = cmd_q;
		stat.raster_skip = skip_q;
		stat.cell_last   = (k_q == 2'd3);
		stat.sp_skip     = !sp_valid_q[idx_q] || r_cur == '0 ||
			adx_q >= {2'b00, r_cur} || ady_q >= {2'b00, r_cur};
		stat.sp_far      = d2_q >= prod_q;
		stat.sp_core     = {d2_q, 2'b00} <= {2'b00, prod_q};
		stat.sp_last     = (idx_q == SP_IW'(MAX_SPILLS - 1));
		stat.sqrt_last   = (cnt_q == SQRT_LAST);
		stat.div_last    = (cnt_q == DIV_LAST);
	end

	assign friction_factor = res_factor_q;
	assign status          = res_status_q;

endmodule

@@ src/friction_field_sampler.sv @@
// Load, add and remove pass through the decode and done states only.
// A sample skips the raster cell accumulation when the point misses the raster,
// then visits every spill slot, using the 32-step square root and 16-step
// divider shared across slots.
// One transaction at a time: busy stays high until the done cycle ends.
// arst_n clears the controller, configuration registers and spill valid bits;
// grid contents are undefined until loaded. Results cannot be stalled.
module friction_field_sampler (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 command,
	input  logic signed [31:0]         point_x,
	input  logic signed [31:0]         point_y,
	input  logic [15:0]                cell_index,
	input  logic [15:0]                factor_value,
	input  logic [7:0]                 spill_tag,
	input  logic [30:0]                spill_radius,
	input  logic                       cfg_we,
	input  logic [ffs_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ffs_pkg::CFG_DW-1:0] cfg_data,
	output logic                       done,
	output logic [15:0]                friction_factor,
	output logic                       status
);
	import ffs_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	ffs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	ffs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.command         (command),
		.point_x         (point_x),
		.point_y         (point_y),
		.cell_index      (cell_index),
		.factor_value    (factor_value),
		.spill_tag       (spill_tag),
		.spill_radius    (spill_radius),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (dp_cmd),
		.stat            (dp_stat),
		.friction_factor (friction_factor),
		.status          (status)
	);

`include "friction_field_sampler_assert.svh"

	`FFS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
	`FFS_ASSERT_NEXT(a_done_idle, done, !busy)
	`FFS_ASSERT_NOW(a_full_no_factor, done && status, friction_factor == 16'd0)

endmodule
